>>> design/elpd_pkg.sv
// Shared types and constants for the endpoint list parser with duplicate filter.
// Used by the cell, the cell row, the top level and the port checkers.
package elpd_pkg;

  localparam int unsigned KEY_W = 48;

  localparam logic [7:0] HDR_FF  = 8'hFF;
  localparam logic [7:0] HDR_TAG = 8'h64;
  localparam logic [7:0] HDR_NL  = 8'h0A;
  localparam logic [7:0] HDR_NUL = 8'h00;
  localparam logic [2:0] HDR_LEN   = 3'd6;
  localparam logic [2:0] HDR_FF_N  = 3'd4;
  localparam logic [2:0] ENTRY_LEN = 3'd6;

  localparam logic CFG_TABLE_LIMIT = 1'b0;
  localparam logic CFG_GAME_TAG    = 1'b1;

  localparam logic KIND_ENTRY   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    PS_HEADER,
    PS_ENTRIES,
    PS_REJECTED,
    PS_ENDED
  } pkt_status_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_MATCH,
    CS_REDUCE,
    CS_DECIDE,
    CS_SUMMARY
  } ctl_state_t;

  typedef struct packed {
    logic              shift;
    logic [KEY_W-1:0]  key;
  } row_ctrl_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] ip;
    logic [15:0] port;
    logic [7:0]  slot;
    logic [3:0]  game;
    logic [8:0]  added;
    logic        hok;
    logic        last;
  } result_t;

endpackage

>>> design/elpd_cell.sv
// One table cell: holds one stored entry, compares it with the search key.
// Depends on elpd_pkg for the control struct.
module elpd_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 9
) (
  input  logic                    clk,
  input  elpd_pkg::row_ctrl_t     ctrl,
  input  logic [elpd_pkg::KEY_W-1:0] data_in,
  input  logic [CW-1:0]           entry_count,
  output logic [elpd_pkg::KEY_W-1:0] data_out,
  output logic                    match
);
  import elpd_pkg::*;

  logic [KEY_W-1:0] data;
  logic             live;

  assign live     = CW'(IDX) < entry_count;
  assign data_out = data;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      data <= data_in;
    end
    match <= live && (data == ctrl.key);
  end

endmodule

>>> design/elpd_cell_row.sv
// Row of table cells: new entries shift in at cell zero, every cell matches in parallel.
// Depends on elpd_pkg and elpd_cell.
module elpd_cell_row #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned CW    = 9
) (
  input  logic                clk,
  input  elpd_pkg::row_ctrl_t ctrl,
  input  logic [CW-1:0]       entry_count,
  output logic                hit
);
  import elpd_pkg::*;

  logic [KEY_W-1:0] chain [DEPTH+1];
  logic [DEPTH-1:0] match_vec;

  assign chain[0] = ctrl.key;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    elpd_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .data_in     (chain[g]),
      .entry_count (entry_count),
      .data_out    (chain[g+1]),
      .match       (match_vec[g])
    );
  end

  always_ff @(posedge clk) begin
    hit <= |match_vec;
  end

endmodule

>>> design/endpoint_list_parser_dedup.sv
// Endpoint list parser with duplicate filter: header check, entry assembly, table insert.
// Timing: a byte that completes a new entry goes through cell compare, match reduction and
// decide before its result queues. A full output queue stalls input.
// Throughput: 1 byte per cycle, except a byte that ends an entry bound for the table search,
// which holds input until the search and, if it also ends the packet, the summary are done.
// Reset (rst, synchronous): table empty, configuration to defaults, output queue empty.
module endpoint_list_parser_dedup #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_value,
  input  logic        first_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [31:0] server_ip,
  output logic [15:0] server_port,
  output logic [7:0]  slot_index,
  output logic [3:0]  entry_game,
  output logic [8:0]  added_total,
  output logic        header_ok,
  output logic        last_result
);
  import elpd_pkg::*;

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned LW = (CW > 9) ? CW : 9;

  logic [8:0]        table_limit;
  logic [3:0]        game_tag;

  ctl_state_t        state, state_next;
  pkt_status_t       status;
  logic [2:0]        hdr_pos;
  logic [2:0]        byte_idx;
  logic [39:0]       asm_reg;
  logic [8:0]        packet_added;
  logic [CW-1:0]     entry_count;
  logic [KEY_W-1:0]  key_reg;
  logic              last_pend;
  logic              hit;

  pkt_status_t       st_c, st_next;
  logic [2:0]        hp_c, hp_next, bi_c, bi_next;
  logic [39:0]       asm_c, asm_next;
  logic [8:0]        added_c, added_next;
  logic [KEY_W-1:0]  key_c;
  logic              hdr_byte_ok, cand, sum_hok, count_ok;
  logic [LW-1:0]     lim;

  logic              accept, push, pop, room, shift;
  result_t           push_res;
  result_t           q0, q1;
  logic [1:0]        qcnt;
  logic [1:0]        wi;
  row_ctrl_t         row_ctrl;

  assign in_ready = (state == CS_IDLE) && (qcnt != 2'd2);
  assign accept = in_valid && in_ready;
  assign pop    = out_valid && out_ready;
  assign room   = (qcnt != 2'd2) || pop;

  assign lim = (LW'(table_limit) < LW'(TABLE_DEPTH)) ? LW'(table_limit) : LW'(TABLE_DEPTH);
  assign count_ok = LW'(entry_count) < lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_limit <= 9'd256;
      game_tag    <= 4'd0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_TABLE_LIMIT: table_limit <= cfg_data;
        CFG_GAME_TAG:    game_tag    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    st_c    = first_byte ? PS_HEADER : status;
    hp_c    = first_byte ? 3'd0 : hdr_pos;
    bi_c    = first_byte ? 3'd0 : byte_idx;
    asm_c   = first_byte ? 40'd0 : asm_reg;
    added_c = first_byte ? 9'd0 : packet_added;
    key_c   = {asm_c, byte_value};

    if (hp_c < HDR_FF_N) begin
      hdr_byte_ok = byte_value == HDR_FF;
    end else if (hp_c == HDR_FF_N) begin
      hdr_byte_ok = byte_value == HDR_TAG;
    end else begin
      hdr_byte_ok = byte_value inside {HDR_NL, HDR_NUL};
    end

    st_next    = st_c;
    hp_next    = hp_c;
    bi_next    = bi_c;
    asm_next   = asm_c;
    added_next = added_c;
    cand       = 1'b0;

    case (st_c)
      PS_HEADER: begin
        if (!hdr_byte_ok) begin
          st_next = PS_REJECTED;
        end else begin
          hp_next = hp_c + 3'd1;
          if (hp_c == HDR_LEN - 3'd1) begin
            st_next = PS_ENTRIES;
          end
        end
      end
      PS_ENTRIES: begin
        if (bi_c != ENTRY_LEN - 3'd1) begin
          asm_next = {asm_c[31:0], byte_value};
          bi_next  = bi_c + 3'd1;
        end else begin
          bi_next  = 3'd0;
          asm_next = 40'd0;
          if (key_c == '0) begin
            st_next = PS_ENDED;
          end else if (key_c[15:0] != 16'd0 && count_ok) begin
            cand = 1'b1;
          end
        end
      end
      default: ;
    endcase

    sum_hok = (st_next == PS_ENTRIES) || (st_next == PS_ENDED);

    if (last_byte) begin
      st_next  = PS_HEADER;
      hp_next  = 3'd0;
      bi_next  = 3'd0;
      asm_next = 40'd0;
      if (!cand) begin
        added_next = 9'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    push       = 1'b0;
    push_res   = '0;
    shift      = 1'b0;
    case (state)
      CS_IDLE: begin
        if (accept) begin
          if (cand) begin
            state_next = CS_MATCH;
          end else if (last_byte) begin
            push           = 1'b1;
            push_res.kind  = KIND_SUMMARY;
            push_res.added = added_c;
            push_res.hok   = sum_hok;
            push_res.last  = 1'b1;
          end
        end
      end
      CS_MATCH:  state_next = CS_REDUCE;
      CS_REDUCE: state_next = CS_DECIDE;
      CS_DECIDE: begin
        if (hit) begin
          state_next = last_pend ? CS_SUMMARY : CS_IDLE;
        end else if (room) begin
          push          = 1'b1;
          shift         = 1'b1;
          push_res.kind = KIND_ENTRY;
          push_res.ip   = key_reg[47:16];
          push_res.port = key_reg[15:0];
          push_res.slot = 8'(entry_count);
          push_res.game = game_tag;
          push_res.hok  = 1'b1;
          push_res.last = !last_pend;
          state_next    = last_pend ? CS_SUMMARY : CS_IDLE;
        end
      end
      CS_SUMMARY: begin
        if (room) begin
          push           = 1'b1;
          push_res.kind  = KIND_SUMMARY;
          push_res.added = packet_added;
          push_res.hok   = 1'b1;
          push_res.last  = 1'b1;
          state_next     = CS_IDLE;
        end
      end
      default: state_next = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status       <= PS_HEADER;
      hdr_pos      <= 3'd0;
      byte_idx     <= 3'd0;
      asm_reg      <= 40'd0;
      packet_added <= 9'd0;
      entry_count  <= '0;
      last_pend    <= 1'b0;
    end else begin
      if (accept) begin
        status       <= st_next;
        hdr_pos      <= hp_next;
        byte_idx     <= bi_next;
        asm_reg      <= asm_next;
        packet_added <= added_next;
        last_pend    <= last_byte && cand;
      end
      if (shift) begin
        entry_count  <= entry_count + CW'(1);
        packet_added <= packet_added + 9'd1;
      end
      if (state == CS_SUMMARY && room) begin
        packet_added <= 9'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_reg <= key_c;
    end
  end

  assign row_ctrl.shift = shift;
  assign row_ctrl.key   = key_reg;

  elpd_cell_row #(
    .DEPTH (TABLE_DEPTH),
    .CW    (CW)
  ) u_row (
    .clk         (clk),
    .ctrl        (row_ctrl),
    .entry_count (entry_count),
    .hit         (hit)
  );

  assign wi = pop ? qcnt - 2'd1 : qcnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      qcnt <= 2'd0;
    end else begin
      qcnt <= qcnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push && wi == 2'd0) begin
      q0 <= push_res;
    end else if (pop) begin
      q0 <= q1;
    end
    if (push && wi != 2'd0) begin
      q1 <= push_res;
    end
  end

  assign out_valid   = qcnt != 2'd0;
  assign result_kind = q0.kind;
  assign server_ip   = q0.ip;
  assign server_port = q0.port;
  assign slot_index  = q0.slot;
  assign entry_game  = q0.game;
  assign added_total = q0.added;
  assign header_ok   = q0.hok;
  assign last_result = q0.last;

endmodule

>>> design/elpd_checker.sv
// Port-level checks for the endpoint list parser, bound to the top level.
// Depends on elpd_pkg for result kind codes.
module elpd_sva (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        result_kind,
  input logic [31:0] server_ip,
  input logic [15:0] server_port,
  input logic [7:0]  slot_index,
  input logic [3:0]  entry_game,
  input logic [8:0]  added_total,
  input logic        header_ok,
  input logic        last_result
);
  import elpd_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(server_ip)
      && $stable(server_port) && $stable(added_total) && $stable(last_result))
    else $error("stalled result beat changed");

  a_summary_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_SUMMARY |-> server_ip == 32'd0 && server_port == 16'd0
      && slot_index == 8'd0 && entry_game == 4'd0 && last_result)
    else $error("summary beat carries entry fields or is not last");

  a_entry_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_ENTRY |-> header_ok && added_total == 9'd0
      && server_port != 16'd0)
    else $error("entry beat malformed");

endmodule

bind endpoint_list_parser_dedup elpd_sva u_elpd_sva (.*);

>>> tb/elpd_checker.sv
// Port checker for the endpoint list parser: mirrors header, entry and table state per beat,
// queues the results each input beat should cause and compares every output beat to them.
// Depends on elpd_pkg for the result layout, header bytes, register codes and status codes.
module elpd_checker #(
  parameter int unsigned DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  byte_value,
  input  logic        first_byte,
  input  logic        last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        result_kind,
  input  logic [31:0] server_ip,
  input  logic [15:0] server_port,
  input  logic [7:0]  slot_index,
  input  logic [3:0]  entry_game,
  input  logic [8:0]  added_total,
  input  logic        header_ok,
  input  logic        last_result,
  output int          fail_count,
  output int          outstanding,
  output int          table_fill,
  output int          entries_seen,
  output int          summaries_seen
);
  import elpd_pkg::*;

  logic [KEY_W-1:0] stored_keys [DEPTH];
  int unsigned      stored_count;
  int unsigned      hdr_pos;
  int unsigned      entry_pos;
  logic [39:0]      entry_bytes;
  pkt_status_t      status;
  int unsigned      pkt_added;
  int unsigned      limit_reg;
  logic [3:0]       game_reg;
  result_t          expected_results [$];

  task automatic report_error(string msg);
    $display("[%0t] check error: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_error($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  function automatic bit header_byte_good(int unsigned pos, logic [7:0] b);
    if (pos < HDR_FF_N) return b == HDR_FF;
    if (pos == HDR_FF_N) return b == HDR_TAG;
    return b == HDR_NL || b == HDR_NUL;
  endfunction

  task automatic clear_packet();
    hdr_pos     = 0;
    entry_pos   = 0;
    entry_bytes = '0;
    status      = PS_HEADER;
    pkt_added   = 0;
  endtask

  task automatic parse_beat(logic [7:0] b, logic first, logic last);
    result_t          made [2];
    int               produced;
    logic [31:0]      ip;
    logic [15:0]      port;
    logic [KEY_W-1:0] key;
    bit               dup;
    int unsigned      cap;
    produced = 0;
    if (first) clear_packet();
    case (status)
      PS_HEADER: begin
        if (!header_byte_good(hdr_pos, b)) begin
          status = PS_REJECTED;
        end else begin
          hdr_pos++;
          if (hdr_pos >= HDR_LEN) status = PS_ENTRIES;
        end
      end
      PS_ENTRIES: begin
        if (entry_pos < ENTRY_LEN - 1) begin
          entry_bytes = {entry_bytes[31:0], b};
          entry_pos++;
        end else begin
          ip          = entry_bytes[39:8];
          port        = {entry_bytes[7:0], b};
          key         = {ip, port};
          entry_pos   = 0;
          entry_bytes = '0;
          if (key == '0) begin
            status = PS_ENDED;
          end else if (port != 16'd0) begin
            cap = (limit_reg < DEPTH) ? limit_reg : DEPTH;
            if (stored_count < cap) begin
              dup = 1'b0;
              for (int j = 0; j < stored_count; j++)
                if (stored_keys[j] == key) dup = 1'b1;
              if (!dup) begin
                stored_keys[stored_count] = key;
                made[produced] = '{kind: KIND_ENTRY, ip: ip, port: port,
                                   slot: 8'(stored_count), game: game_reg,
                                   added: 9'd0, hok: 1'b1, last: 1'b0};
                produced++;
                stored_count++;
                pkt_added++;
              end
            end
          end
        end
      end
      default: ;
    endcase
    if (last) begin
      made[produced] = '{kind: KIND_SUMMARY, ip: 32'd0, port: 16'd0, slot: 8'd0,
                         game: 4'd0, added: 9'(pkt_added),
                         hok: (status == PS_ENTRIES || status == PS_ENDED),
                         last: 1'b0};
      produced++;
      clear_packet();
    end
    for (int k = 0; k < produced; k++) begin
      if (k == produced - 1) made[k].last = 1'b1;
      expected_results.push_back(made[k]);
    end
  endtask

  always @(posedge clk) begin : monitor
    result_t seen;
    result_t want;
    if (rst) begin
      stored_count = 0;
      limit_reg    = 256;
      game_reg     = 4'd0;
      clear_packet();
      expected_results.delete();
    end else begin
      if (cfg_write_en) begin
        if (cfg_index == CFG_TABLE_LIMIT) limit_reg = 32'(cfg_data);
        else game_reg = cfg_data[3:0];
      end
      if (in_valid && in_ready) parse_beat(byte_value, first_byte, last_byte);
      if (out_valid && out_ready) begin
        seen = '{kind: result_kind, ip: server_ip, port: server_port, slot: slot_index,
                 game: entry_game, added: added_total, hok: header_ok, last: last_result};
        if (expected_results.size() == 0) begin
          report_error($sformatf("result beat of kind %0d with nothing expected", seen.kind));
        end else begin
          want = expected_results.pop_front();
          check_field("result_kind", 32'(seen.kind), 32'(want.kind));
          check_field("server_ip", seen.ip, want.ip);
          check_field("server_port", 32'(seen.port), 32'(want.port));
          check_field("slot_index", 32'(seen.slot), 32'(want.slot));
          check_field("entry_game", 32'(seen.game), 32'(want.game));
          check_field("added_total", 32'(seen.added), 32'(want.added));
          check_field("header_ok", 32'(seen.hok), 32'(want.hok));
          check_field("last_result", 32'(seen.last), 32'(want.last));
          if (want.kind == KIND_ENTRY) entries_seen++;
          else summaries_seen++;
        end
      end
    end
    outstanding <= expected_results.size();
    table_fill  <= stored_count;
  end

endmodule

>>> tb/tb_top.sv
// Top of the endpoint list parser bench: clock, reset, packet stimulus, register phases, verdict.
// Instantiates endpoint_list_parser_dedup and elpd_checker; depends on elpd_pkg for codes.
module tb_top;
  import elpd_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic        cfg_index = CFG_TABLE_LIMIT;
  logic [8:0]  cfg_data = 9'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  byte_value = 8'd0;
  logic        first_byte = 1'b0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        result_kind;
  logic [31:0] server_ip;
  logic [15:0] server_port;
  logic [7:0]  slot_index;
  logic [3:0]  entry_game;
  logic [8:0]  added_total;
  logic        header_ok;
  logic        last_result;
  int          fail_count;
  int          outstanding;
  int          table_fill;
  int          entries_seen;
  int          summaries_seen;

  int               cycles = 0;
  int               beats_sent = 0;
  int               packets_sent = 0;
  bit               send_burst = 1'b0;
  bit               recv_burst = 1'b0;
  logic [7:0]       pkt [$];
  logic [KEY_W-1:0] key_pool [$];

  endpoint_list_parser_dedup dut (.*);
  elpd_checker checker_i (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : drain
    int w;
    forever begin
      if ($urandom_range(0, 31) == 0) recv_burst = ~recv_burst;
      w = recv_burst ? 0 : $urandom_range(0, 19);
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic send_beat(logic [7:0] b, logic f, logic l);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    byte_value <= b;
    first_byte <= f;
    last_byte  <= l;
    do @(posedge clk); while (!(in_valid && in_ready));
    beats_sent++;
  endtask

  task automatic send_packet(bit mark_first, bit mark_last);
    for (int i = 0; i < pkt.size(); i++)
      send_beat(pkt[i], mark_first && i == 0, mark_last && i == pkt.size() - 1);
    if (mark_last) packets_sent++;
    pkt.delete();
  endtask

  task automatic add_header(bit newline);
    repeat (HDR_FF_N) pkt.push_back(HDR_FF);
    pkt.push_back(HDR_TAG);
    pkt.push_back(newline ? HDR_NL : HDR_NUL);
  endtask

  task automatic add_key(logic [KEY_W-1:0] key);
    for (int i = 5; i >= 0; i--) pkt.push_back(key[8*i +: 8]);
  endtask

  task automatic add_new_key();
    logic [KEY_W-1:0] key;
    key = {32'($urandom()), 16'($urandom_range(1, 65535))};
    key_pool.push_back(key);
    add_key(key);
  endtask

  task automatic send_random_packet();
    int          sel;
    int          n;
    int          r;
    int          p;
    logic [7:0]  v;
    if ($urandom_range(0, 7) == 0) send_burst = ~send_burst;
    if ($urandom_range(0, 19) == 0) begin
      add_header(1'($urandom_range(0, 1)));
      repeat ($urandom_range(1, 7)) pkt.push_back(8'($urandom()));
      send_packet(1'b1, 1'b0);
    end
    sel = $urandom_range(0, 99);
    if (sel < 6) begin
      repeat ($urandom_range(1, 10)) pkt.push_back(8'($urandom()));
    end else if (sel < 12) begin
      add_header(1'($urandom_range(0, 1)));
      n = $urandom_range(1, 5);
      while (pkt.size() > n) void'(pkt.pop_back());
    end else begin
      add_header(1'($urandom_range(0, 1)));
      if (sel < 20) begin
        p = $urandom_range(0, 5);
        if (p == 5) begin
          v = 8'($urandom_range(1, 255));
          if (v == HDR_NL) v = 8'h0B;
          pkt[p] = v;
        end else begin
          pkt[p] = pkt[p] ^ 8'($urandom_range(1, 255));
        end
      end
      n = $urandom_range(0, 6);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 55) add_new_key();
        else if (r < 80 && key_pool.size() > 0)
          add_key(key_pool[$urandom_range(0, key_pool.size() - 1)]);
        else if (r < 90) add_key({32'($urandom()), 16'd0});
        else if (r < 95) add_key('0);
        else add_new_key();
      end
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 5)) pkt.push_back(8'($urandom()));
    end
    send_packet($urandom_range(0, 99) < 85, 1'b1);
  endtask

  task automatic settle();
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(logic [8:0] limit, logic [3:0] game);
    cfg_write_en <= 1'b1;
    cfg_index    <= CFG_TABLE_LIMIT;
    cfg_data     <= limit;
    @(posedge clk);
    cfg_index <= CFG_GAME_TAG;
    cfg_data  <= {5'd0, game};
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  initial begin : stimulus
    int          goal [5];
    logic [3:0]  tags [5];
    int          lim;
    goal = '{420, 560, 700, 900, 1320};
    tags = '{4'd3, 4'd15, 4'd9, 4'd12, 4'd0};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    configure(9'd256, 4'd5);

    add_header(1'b0);
    add_key({32'hFFFF_FFFF, 16'hFFFF});
    send_packet(1'b1, 1'b1);
    pkt = '{HDR_FF, 8'h00};
    send_packet(1'b0, 1'b1);
    pkt = '{HDR_FF};
    send_packet(1'b1, 1'b1);
    add_header(1'b1);
    add_key('0);
    pkt.push_back(8'hA5);
    send_packet(1'b1, 1'b1);
    in_valid <= 1'b0;
    settle();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: lim = 0;
        2: lim = table_fill / 2;
        3: lim = (table_fill + 3 > 256) ? 256 : table_fill + 3;
        default: lim = 256;
      endcase
      configure(9'(lim), tags[ph]);
      while (beats_sent < goal[ph]) send_random_packet();
      in_valid <= 1'b0;
      settle();
    end

    $display("Sent %0d bytes in %0d packets across five limit and tag settings.",
             beats_sent, packets_sent);
    $display("Compared %0d added entries and %0d summaries; table ended with %0d entries.",
             entries_seen, summaries_seen, table_fill);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
